@@ hdl/great_circle_dead_reckoning_top_defines.svh @@
// assertion macros for the great-circle dead reckoning block
// used by gcdr_ctrl, the module that carries concurrent assertions, needs nothing else
`ifndef GREAT_CIRCLE_DEAD_RECKONING_TOP_DEFINES_SVH
`define GREAT_CIRCLE_DEAD_RECKONING_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define GCDR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GCDR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GCDR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GCDR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/gcdr_pkg.sv @@
// shared types and constants of the great-circle dead reckoning block
// no dependencies
package gcdr_pkg;

    localparam int MUL_W    = 36;
    localparam int CORDIC_W = 64;
    localparam int SHIFT_W  = 6;

    localparam logic signed [31:0] K_GAIN = 32'sd652032874;
    localparam logic signed [31:0] START_LAT_RESET = 32'sd404949798;
    localparam logic signed [31:0] START_LON_RESET = 32'sd1412663658;
    localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A94;
    localparam logic signed [CORDIC_W-1:0] NORM_TOP = 64'sh0800_0000_0000_0000;
    localparam logic signed [CORDIC_W-1:0] NORM_FAST = 64'sh0080_0000_0000_0000;

    localparam logic [1:0] CFG_START_LAT = 2'd0;
    localparam logic [1:0] CFG_START_LON = 2'd1;
    localparam logic [1:0] CFG_HEADING   = 2'd2;
    localparam logic [1:0] CFG_STEP      = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RELOAD, ST_ROT_LD, ST_ROT_IT, ST_ROT_ST,
        ST_M_SLCD, ST_T1_A, ST_M_CLSD, ST_M_PCH_A, ST_ADD_A,
        ST_M_CLCD, ST_T1_B, ST_M_SLSD, ST_M_PCH_B, ST_SUB_B,
        ST_M_SHSD, ST_MV_C, ST_VEC_LD, ST_VEC_NORM, ST_VEC_IT, ST_VEC_ST,
        ST_M_MAGK, ST_MV_H, ST_M_SLA, ST_MV_XX, ST_M_CCL, ST_COMMIT
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ROT_LOAD, OP_VEC_LOAD, OP_NORM, OP_PREP, OP_ITER_ROT,
        OP_ITER_VEC, OP_ROT_STORE, OP_VEC_STORE, OP_MUL, OP_MOVE, OP_COMMIT,
        OP_RELOAD
    } dp_op_t;

    typedef enum logic [1:0] {RS_LAT, RS_STEP, RS_HEAD} rot_sel_t;
    typedef enum logic [1:0] {VS_BC, VS_HA, VS_XY} vec_sel_t;

    typedef enum logic [3:0] {
        MS_SL_CD, MS_CL_SD, MS_P_CH, MS_CL_CD, MS_SL_SD, MS_SH_SD,
        MS_MAG_K, MS_SL_A, MS_C_CL
    } mul_sel_t;

    typedef enum logic [2:0] {MV_T1, MV_A, MV_B, MV_C, MV_H, MV_XX} mv_sel_t;

    typedef struct packed {
        dp_op_t   op;
        rot_sel_t rsel;
        vec_sel_t vsel;
        mul_sel_t msel;
        mv_sel_t  mv;
    } dp_cmd_t;

    typedef struct packed {
        logic it_last;
        logic norm_done;
    } dp_stat_t;

endpackage

@@ hdl/gcdr_ctrl.sv @@
// sequencer of the dead reckoning block: steps the datapath through one request
// depends on gcdr_pkg and the assertion macro header
`include "great_circle_dead_reckoning_top_defines.svh"

module gcdr_ctrl
    import gcdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     reload,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctl_state_t state_reg, state_next;
    rot_sel_t   rsel_reg, rsel_next;
    vec_sel_t   vsel_reg, vsel_next;
    logic       out_valid_reg, out_valid_next;
    logic       free;
    logic       fire;

    assign free      = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsel_reg      <= RS_LAT;
            vsel_reg      <= VS_BC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsel_reg      <= rsel_next;
            vsel_reg      <= vsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        rsel_next  = rsel_reg;
        vsel_next  = vsel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = reload ? ST_RELOAD : ST_ROT_LD;
                    rsel_next  = RS_LAT;
                end
            end
            ST_RELOAD:   if (free) state_next = ST_IDLE;
            ST_ROT_LD:   state_next = ST_ROT_IT;
            ST_ROT_IT:   if (stat.it_last) state_next = ST_ROT_ST;
            ST_ROT_ST:
            begin
                unique case (rsel_reg)
                    RS_LAT:
                    begin
                        rsel_next  = RS_STEP;
                        state_next = ST_ROT_LD;
                    end
                    RS_STEP:
                    begin
                        rsel_next  = RS_HEAD;
                        state_next = ST_ROT_LD;
                    end
                    default: state_next = ST_M_SLCD;
                endcase
            end
            ST_M_SLCD:   state_next = ST_T1_A;
            ST_T1_A:     state_next = ST_M_CLSD;
            ST_M_CLSD:   state_next = ST_M_PCH_A;
            ST_M_PCH_A:  state_next = ST_ADD_A;
            ST_ADD_A:    state_next = ST_M_CLCD;
            ST_M_CLCD:   state_next = ST_T1_B;
            ST_T1_B:     state_next = ST_M_SLSD;
            ST_M_SLSD:   state_next = ST_M_PCH_B;
            ST_M_PCH_B:  state_next = ST_SUB_B;
            ST_SUB_B:    state_next = ST_M_SHSD;
            ST_M_SHSD:   state_next = ST_MV_C;
            ST_MV_C:
            begin
                vsel_next  = VS_BC;
                state_next = ST_VEC_LD;
            end
            ST_VEC_LD:   state_next = ST_VEC_NORM;
            ST_VEC_NORM: if (stat.norm_done) state_next = ST_VEC_IT;
            ST_VEC_IT:   if (stat.it_last) state_next = ST_VEC_ST;
            ST_VEC_ST:
            begin
                unique case (vsel_reg)
                    VS_BC:   state_next = ST_M_MAGK;
                    VS_HA:   state_next = ST_M_SLA;
                    default: state_next = ST_COMMIT;
                endcase
            end
            ST_M_MAGK:   state_next = ST_MV_H;
            ST_MV_H:
            begin
                vsel_next  = VS_HA;
                state_next = ST_VEC_LD;
            end
            ST_M_SLA:    state_next = ST_MV_XX;
            ST_MV_XX:    state_next = ST_M_CCL;
            ST_M_CCL:
            begin
                vsel_next  = VS_XY;
                state_next = ST_VEC_LD;
            end
            ST_COMMIT:   if (free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd      = '{op: OP_NONE, rsel: rsel_reg, vsel: vsel_reg,
                     msel: MS_SL_CD, mv: MV_T1};
        fire     = 1'b0;
        unique case (state_reg)
            ST_RELOAD:
            begin
                fire = free;
                if (free) cmd.op = OP_RELOAD;
            end
            ST_ROT_LD:   cmd.op = OP_ROT_LOAD;
            ST_ROT_IT:   cmd.op = OP_ITER_ROT;
            ST_ROT_ST:   cmd.op = OP_ROT_STORE;
            ST_M_SLCD:   begin cmd.op = OP_MUL;  cmd.msel = MS_SL_CD; end
            ST_T1_A:     begin cmd.op = OP_MOVE; cmd.mv   = MV_T1;    end
            ST_M_CLSD:   begin cmd.op = OP_MUL;  cmd.msel = MS_CL_SD; end
            ST_M_PCH_A:  begin cmd.op = OP_MUL;  cmd.msel = MS_P_CH;  end
            ST_ADD_A:    begin cmd.op = OP_MOVE; cmd.mv   = MV_A;     end
            ST_M_CLCD:   begin cmd.op = OP_MUL;  cmd.msel = MS_CL_CD; end
            ST_T1_B:     begin cmd.op = OP_MOVE; cmd.mv   = MV_T1;    end
            ST_M_SLSD:   begin cmd.op = OP_MUL;  cmd.msel = MS_SL_SD; end
            ST_M_PCH_B:  begin cmd.op = OP_MUL;  cmd.msel = MS_P_CH;  end
            ST_SUB_B:    begin cmd.op = OP_MOVE; cmd.mv   = MV_B;     end
            ST_M_SHSD:   begin cmd.op = OP_MUL;  cmd.msel = MS_SH_SD; end
            ST_MV_C:     begin cmd.op = OP_MOVE; cmd.mv   = MV_C;     end
            ST_VEC_LD:   cmd.op = OP_VEC_LOAD;
            ST_VEC_NORM: cmd.op = stat.norm_done ? OP_PREP : OP_NORM;
            ST_VEC_IT:   cmd.op = OP_ITER_VEC;
            ST_VEC_ST:   cmd.op = OP_VEC_STORE;
            ST_M_MAGK:   begin cmd.op = OP_MUL;  cmd.msel = MS_MAG_K; end
            ST_MV_H:     begin cmd.op = OP_MOVE; cmd.mv   = MV_H;     end
            ST_M_SLA:    begin cmd.op = OP_MUL;  cmd.msel = MS_SL_A;  end
            ST_MV_XX:    begin cmd.op = OP_MOVE; cmd.mv   = MV_XX;    end
            ST_M_CCL:    begin cmd.op = OP_MUL;  cmd.msel = MS_C_CL;  end
            ST_COMMIT:
            begin
                fire = free;
                if (free) cmd.op = OP_COMMIT;
            end
            default:     cmd.op = OP_NONE;
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || fire;

    `GCDR_ASSERT_NXT(a_commit_shows, clk, rst_n, (state_reg == ST_COMMIT) && free, out_valid)
    `GCDR_ASSERT_NXT(a_rot_holds, clk, rst_n, (state_reg == ST_ROT_IT) && !stat.it_last, state_reg == ST_ROT_IT)
    `GCDR_ASSERT_NXT(a_accept_starts, clk, rst_n, (state_reg == ST_IDLE) && in_valid, (state_reg == ST_ROT_LD) || (state_reg == ST_RELOAD))

endmodule

@@ hdl/gcdr_datapath.sv @@
// datapath: shared cordic unit, one rounding multiplier, working and position registers
// depends on gcdr_pkg, driven by gcdr_ctrl
module gcdr_datapath
    import gcdr_pkg::*;
#(
    parameter int ANGLE_BITS   = 32,
    parameter int CORDIC_STEPS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude
);

    localparam int AB = ANGLE_BITS;
    localparam int CS = CORDIC_STEPS;
    localparam int IW = $clog2(CS);
    localparam int DU = (AB > 32) ? AB - 32 : 0;
    localparam int DN = (AB < 32) ? 32 - AB : 0;
    localparam int RND_TO = (DN > 0) ? (1 << (DN - 1)) : 0;
    localparam int RND_FROM = (DU > 0) ? (1 << (DU - 1)) : 0;
    localparam logic signed [AB-1:0] HALF_ANG = AB'(64'd1 << (AB - 2));
    localparam logic signed [AB-1:0] PI_ANG = AB'(64'd1 << (AB - 1));

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, dv})
            begin
                rem    = rem - {1'b0, dv};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) as a binary angle
    function automatic logic [AB-1:0] atan_entry(input int i);
        logic [63:0]  rad;
        logic [63:0]  t;
        logic [127:0] pr;
        logic [63:0]  q;
        int           k;
        rad = '0;
        if (i == 0)
            return AB'(64'd1 << (AB - 3));
        k = 0;
        while (62 - i * (2 * k + 1) >= 0)
        begin
            t   = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
            rad = k[0] ? rad - t : rad + t;
            k   = k + 1;
        end
        pr = {64'd0, rad} * {64'd0, INV_PI_Q64};
        q  = pr[127:64];
        return AB'((q + (64'd1 << (62 - AB))) >> (63 - AB));
    endfunction

    function automatic logic signed [AB-1:0] to_ang(input logic signed [31:0] v);
        logic signed [32:0]    t;
        logic signed [AB+31:0] w;
        t = 33'(v) + 33'(RND_TO);
        if (AB >= 32)
            w = (AB + 32)'(v) <<< DU;
        else
            w = (AB + 32)'(t >>> DN);
        return w[AB-1:0];
    endfunction

    function automatic logic signed [31:0] from_ang(input logic signed [AB-1:0] v);
        logic signed [AB:0]    t;
        logic signed [AB+31:0] w;
        t = (AB + 1)'(v) + (AB + 1)'(RND_FROM);
        if (AB > 32)
            w = (AB + 32)'(t >>> DU);
        else
            w = (AB + 32)'(v) <<< DN;
        return w[31:0];
    endfunction

    logic [AB-1:0] atab [CS];

    for (genvar gi = 0; gi < CS; gi++)
    begin : g_atab
        localparam logic [AB-1:0] ATAN_VAL = atan_entry(gi);
        assign atab[gi] = ATAN_VAL;
    end

    // configuration and position
    logic signed [31:0] start_lat_reg, start_lon_reg, cur_lat_reg, cur_lon_reg;
    logic [31:0]        heading_reg;
    logic [30:0]        step_reg;

    // working registers
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [AB-1:0]       z_reg, lat2_reg, dlon_reg;
    logic [IW-1:0]              it_reg;
    logic [SHIFT_W-1:0]         s_reg;
    logic                       neg_reg, zero_reg;
    logic signed [MUL_W-1:0]    sl_reg, cl_reg, sd_reg, cd_reg, sh_reg, ch_reg;
    logic signed [MUL_W-1:0]    a_reg, b_reg, c_reg, t1_reg, p_reg, mag_reg;

    logic signed [AB-1:0]       rot_ang, rot_z0;
    logic                       rot_neg;
    logic signed [MUL_W-1:0]    vx, vy, ma, mb;
    logic signed [2*MUL_W-1:0]  prod, prod_rnd;
    logic signed [MUL_W-1:0]    qprod;
    logic signed [CORDIC_W-1:0] ax, ay, mx, xs, ys;
    logic [SHIFT_W-1:0]         nsh;
    logic                       pos;
    logic signed [MUL_W-1:0]    rs_s, rs_c;
    logic signed [AB-1:0]       vec_ang;

    assign latitude  = cur_lat_reg;
    assign longitude = cur_lon_reg;

    // rotation start angle, folded into +-pi/2
    always_comb
    begin
        unique case (cmd.rsel)
            RS_LAT:  rot_ang = to_ang(cur_lat_reg);
            RS_STEP: rot_ang = to_ang({1'b0, step_reg});
            default: rot_ang = to_ang(heading_reg);
        endcase
        rot_z0  = rot_ang;
        rot_neg = 1'b0;
        if (rot_ang > HALF_ANG)
        begin
            rot_z0  = rot_ang - PI_ANG;
            rot_neg = 1'b1;
        end
        else if (rot_ang < -HALF_ANG)
        begin
            rot_z0  = rot_ang + PI_ANG;
            rot_neg = 1'b1;
        end
    end

    always_comb
    begin
        unique case (cmd.vsel)
            VS_BC:
            begin
                vx = b_reg;
                vy = c_reg;
            end
            VS_HA:
            begin
                vx = mag_reg;
                vy = a_reg;
            end
            default:
            begin
                vx = t1_reg;
                vy = p_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.msel)
            MS_SL_CD: begin ma = sl_reg;  mb = cd_reg; end
            MS_CL_SD: begin ma = cl_reg;  mb = sd_reg; end
            MS_P_CH:  begin ma = p_reg;   mb = ch_reg; end
            MS_CL_CD: begin ma = cl_reg;  mb = cd_reg; end
            MS_SL_SD: begin ma = sl_reg;  mb = sd_reg; end
            MS_SH_SD: begin ma = sh_reg;  mb = sd_reg; end
            MS_MAG_K: begin ma = mag_reg; mb = MUL_W'(K_GAIN); end
            MS_SL_A:  begin ma = sl_reg;  mb = a_reg;  end
            default:  begin ma = c_reg;   mb = cl_reg; end
        endcase
    end

    // q30 product rounded half up
    assign prod     = ma * mb;
    assign prod_rnd = prod + (2 * MUL_W)'(64'd1 << 29);
    assign qprod    = MUL_W'(prod_rnd >>> 30);

    assign ax  = x_reg[CORDIC_W-1] ? -x_reg : x_reg;
    assign ay  = y_reg[CORDIC_W-1] ? -y_reg : y_reg;
    assign mx  = (ax > ay) ? ax : ay;
    assign nsh = (mx < NORM_FAST) ? SHIFT_W'(4) : SHIFT_W'(1);
    assign stat.norm_done = (mx >= NORM_TOP) || (mx == '0);
    assign stat.it_last   = (it_reg == IW'(CS - 1));

    assign xs  = x_reg >>> it_reg;
    assign ys  = y_reg >>> it_reg;
    assign pos = (cmd.op == OP_ITER_ROT) ? !z_reg[AB-1] : y_reg[CORDIC_W-1];

    assign rs_s    = neg_reg ? MUL_W'(-y_reg) : MUL_W'(y_reg);
    assign rs_c    = neg_reg ? MUL_W'(-x_reg) : MUL_W'(x_reg);
    assign vec_ang = zero_reg ? '0 : z_reg;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ROT_LOAD:
            begin
                x_reg   <= CORDIC_W'(K_GAIN);
                y_reg   <= '0;
                z_reg   <= rot_z0;
                neg_reg <= rot_neg;
                it_reg  <= '0;
            end
            OP_VEC_LOAD:
            begin
                x_reg    <= CORDIC_W'(vx);
                y_reg    <= CORDIC_W'(vy);
                z_reg    <= '0;
                s_reg    <= '0;
                zero_reg <= (vx == '0) && (vy == '0);
                it_reg   <= '0;
            end
            OP_NORM:
            begin
                x_reg <= x_reg <<< nsh;
                y_reg <= y_reg <<< nsh;
                s_reg <= s_reg + nsh;
            end
            OP_PREP:
            begin
                if (x_reg[CORDIC_W-1])
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                    z_reg <= PI_ANG;
                end
            end
            OP_ITER_ROT, OP_ITER_VEC:
            begin
                x_reg  <= pos ? x_reg - ys : x_reg + ys;
                y_reg  <= pos ? y_reg + xs : y_reg - xs;
                z_reg  <= pos ? z_reg - $signed(atab[it_reg]) : z_reg + $signed(atab[it_reg]);
                it_reg <= it_reg + 1'b1;
            end
            OP_ROT_STORE:
            begin
                unique case (cmd.rsel)
                    RS_LAT:  begin sl_reg <= rs_s; cl_reg <= rs_c; end
                    RS_STEP: begin sd_reg <= rs_s; cd_reg <= rs_c; end
                    default: begin sh_reg <= rs_s; ch_reg <= rs_c; end
                endcase
            end
            OP_VEC_STORE:
            begin
                unique case (cmd.vsel)
                    VS_BC:   mag_reg  <= zero_reg ? '0 : MUL_W'(x_reg >>> s_reg);
                    VS_HA:   lat2_reg <= vec_ang;
                    default: dlon_reg <= vec_ang;
                endcase
            end
            OP_MUL: p_reg <= qprod;
            OP_MOVE:
            begin
                unique case (cmd.mv)
                    MV_T1:   t1_reg  <= p_reg;
                    MV_A:    a_reg   <= t1_reg + p_reg;
                    MV_B:    b_reg   <= t1_reg - p_reg;
                    MV_C:    c_reg   <= p_reg;
                    MV_H:    mag_reg <= p_reg;
                    MV_XX:   t1_reg  <= cd_reg - p_reg;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_lat_reg <= START_LAT_RESET;
            start_lon_reg <= START_LON_RESET;
            heading_reg   <= '0;
            step_reg      <= '0;
            cur_lat_reg   <= START_LAT_RESET;
            cur_lon_reg   <= START_LON_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_START_LAT: start_lat_reg <= cfg_data;
                    CFG_START_LON: start_lon_reg <= cfg_data;
                    CFG_HEADING:   heading_reg   <= cfg_data;
                    default:       step_reg      <= cfg_data[30:0];
                endcase
            end
            if (cmd.op == OP_RELOAD)
            begin
                cur_lat_reg <= start_lat_reg;
                cur_lon_reg <= start_lon_reg;
            end
            else if (cmd.op == OP_COMMIT)
            begin
                cur_lat_reg <= from_ang(lat2_reg);
                cur_lon_reg <= from_ang(to_ang(cur_lon_reg) + dlon_reg);
            end
        end
    end

endmodule

@@ hdl/great_circle_dead_reckoning_top.sv @@
// top level of the great-circle dead reckoning block
// depends on gcdr_pkg, gcdr_ctrl and gcdr_datapath
//
//  channel  signals                                      direction
//  in       in_valid, in_stall, reload                   request in
//  out      out_valid, out_stall, latitude, longitude    request out
//  cfg      cfg_write, cfg_index, cfg_data               register write
//
// an advance runs three cordic rotations and three vectoring passes, each pass
// normalising its vector first, all on the one shared cordic unit with multiplies
// between them; a reload copies the start position into the current one
// one request at a time; a finished result waits in the position registers
// while the next request is taken, which then holds before its update
// reset is asynchronous and loads the start position as the current one
module great_circle_dead_reckoning_top
    import gcdr_pkg::*;
#(
    parameter int ANGLE_BITS   = 32,
    parameter int CORDIC_STEPS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               reload,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    gcdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .reload    (reload),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    gcdr_datapath #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .latitude  (latitude),
        .longitude (longitude)
    );

endmodule

@@ sim/gcdr_position_checker.sv @@
// position checker for the great-circle dead reckoning block: watches the request,
// result and register-write ports, predicts each new position and compares it
// depends on gcdr_pkg only
module gcdr_position_checker
    import gcdr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               reload,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 mismatches,
    output int                 positions_pending
);

    localparam longint HALF_TURN = 64'sd1 << 31;

    typedef struct {
        logic [31:0] lat;
        logic [31:0] lon;
    } position_t;

    logic [31:0] start_lat, start_lon, heading;
    logic [30:0] step;
    logic [31:0] pos_lat, pos_lon;
    longint      arctan_tab [32];
    position_t   expected_positions [$];

    function automatic longint wrap_turn(longint v);
        longint u;
        u = (v + HALF_TURN) & 64'h0000_0000_FFFF_FFFF;
        return u - HALF_TURN;
    endfunction

    function automatic longint sext(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic void rotate(input longint ang, output longint s, output longint c);
        longint x, y, z, xs, ys;
        bit     neg;
        x = K_GAIN;
        y = 0;
        z = wrap_turn(ang);
        neg = 0;
        if (z > HALF_TURN / 2)
        begin
            z -= HALF_TURN;
            neg = 1;
        end
        else if (z < -HALF_TURN / 2)
        begin
            z += HALF_TURN;
            neg = 1;
        end
        for (int i = 0; i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= arctan_tab[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += arctan_tab[i];
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function automatic longint vector_angle(input longint xi, input longint yi,
                                            output longint mag);
        longint x, y, z, ax, ay, mx, xs, ys;
        int     sh;
        x = xi;
        y = yi;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        mx = ax > ay ? ax : ay;
        z = 0;
        sh = 0;
        mag = 0;
        if (mx == 0)
            return 0;
        while (mx < (64'sd1 << 59))
        begin
            mx = mx * 2;
            sh++;
        end
        x = x <<< sh;
        y = y <<< sh;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys;
                y -= xs;
                z += arctan_tab[i];
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= arctan_tab[i];
            end
        end
        mag = fix_mul(x >>> sh, K_GAIN);
        return wrap_turn(z);
    endfunction

    function automatic void advance_position(logic do_reload);
        longint sl, cl, sd, cd, sh, ch, a, b, c, h, lat2, dlon, lon1, xx, yy, unused;
        if (do_reload)
        begin
            pos_lat = start_lat;
            pos_lon = start_lon;
        end
        else
        begin
            lon1 = sext(pos_lon);
            rotate(sext(pos_lat), sl, cl);
            rotate(longint'(step), sd, cd);
            rotate(sext(heading), sh, ch);
            a = fix_mul(sl, cd) + fix_mul(fix_mul(cl, sd), ch);
            b = fix_mul(cl, cd) - fix_mul(fix_mul(sl, sd), ch);
            c = fix_mul(sh, sd);
            unused = vector_angle(b, c, h);
            lat2 = vector_angle(h, a, unused);
            xx = cd - fix_mul(sl, a);
            yy = fix_mul(fix_mul(sh, sd), cl);
            dlon = vector_angle(xx, yy, unused);
            pos_lat = lat2[31:0];
            pos_lon = wrap_turn(lon1 + dlon) & 64'h0000_0000_FFFF_FFFF;
        end
    endfunction

    initial
    begin
        longint         rad, t;
        logic [127:0]   prod;
        logic [63:0]    q;
        arctan_tab[0] = 64'sd1 << 29;
        for (int i = 1; i < 32; i++)
        begin
            rad = 0;
            for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++)
            begin
                t = (64'sd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
                rad += (k % 2 == 1) ? -t : t;
            end
            prod = {64'd0, rad} * {64'd0, INV_PI_Q64};
            q = prod[127:64];
            arctan_tab[i] = longint'((q + (64'd1 << 30)) >> 31);
        end
    end

    assign positions_pending = expected_positions.size();

    always @(posedge clk or negedge rst_n)
    begin
        position_t exp_pos;
        if (!rst_n)
        begin
            start_lat <= START_LAT_RESET;
            start_lon <= START_LON_RESET;
            heading <= '0;
            step <= '0;
            pos_lat = START_LAT_RESET;
            pos_lon = START_LON_RESET;
            mismatches <= 0;
            expected_positions.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_START_LAT: start_lat <= cfg_data;
                    CFG_START_LON: start_lon <= cfg_data;
                    CFG_HEADING:   heading <= cfg_data;
                    CFG_STEP:      step <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance_position(reload);
                exp_pos.lat = pos_lat;
                exp_pos.lon = pos_lon;
                expected_positions.push_back(exp_pos);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected position lat %0d lon %0d", latitude, longitude);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_pos = expected_positions.pop_front();
                    if (latitude !== exp_pos.lat || longitude !== exp_pos.lon)
                    begin
                        if (mismatches < 10)
                            $display("position mismatch: lat exp %0d got %0d, lon exp %0d got %0d",
                                     $signed(exp_pos.lat), latitude,
                                     $signed(exp_pos.lon), longitude);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_great_circle_dead_reckoning_top.sv @@
// testbench top for the great-circle dead reckoning block: drives directed and
// random tick requests and register settings, with random idling on both sides
// depends on gcdr_pkg, gcdr_position_checker and great_circle_dead_reckoning_top
module tb_great_circle_dead_reckoning_top;
    import gcdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int RANDOM_TICKS   = 1700;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               reload;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 mismatches;
    int                 positions_pending;
    bit                 no_gaps;
    int                 idle_cycles;

    great_circle_dead_reckoning_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .reload    (reload),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .latitude  (latitude),
        .longitude (longitude),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gcdr_position_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .reload            (reload),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .latitude          (latitude),
        .longitude         (longitude),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .positions_pending (positions_pending)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #4 clk = ~clk;
    end

    // watchdog over cycles with no transfer on any port
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side stalls
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    task automatic send_tick(input logic do_reload);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        reload <= do_reload;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (positions_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic set_route(input logic [31:0] lat, input logic [31:0] lon,
                             input logic [31:0] head, input logic [31:0] stp);
        settle();
        write_reg(CFG_START_LAT, lat);
        write_reg(CFG_START_LON, lon);
        write_reg(CFG_HEADING, head);
        write_reg(CFG_STEP, stp);
        cfg_write <= 1'b0;
    endtask

    task automatic directed_leg(input logic [31:0] lat, input logic [31:0] lon,
                                input logic [31:0] head, input logic [31:0] stp);
        set_route(lat, lon, head, stp);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    initial
    begin
        int     sent;
        int     leg_len;
        longint lat_r;
        logic [31:0] stp_r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        reload = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_START_LAT;
        cfg_data = '0;
        no_gaps = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset position, zero step
        send_tick(1'b0);
        send_tick(1'b1);
        // north pole, heading south, quarter turn step
        directed_leg(32'h4000_0000, 32'h0000_0000, 32'h8000_0000, 32'h4000_0000);
        // south pole, heading just short of north, smallest step
        directed_leg(32'hC000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        // equator near the date line heading east, longitude wraps
        directed_leg(32'h0000_0000, 32'h7FFF_FFFF, 32'h4000_0000, 32'h1000_0000);
        // heading west across the date line, step beyond a quarter turn
        directed_leg(32'h1000_0000, 32'h8000_0000, 32'hC000_0000, 32'h7FFF_FFFF);
        // latitude beyond the pole, zero heading, large step
        directed_leg(32'h7FFF_FFFF, 32'h1234_5678, 32'h0000_0000, 32'h3FFF_FFFF);

        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            lat_r = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
            case ($urandom_range(0, 3))
                0: stp_r = $urandom_range(0, 32'h4000_0000);
                1: stp_r = $urandom & 32'h7FFF_FFFF;
                default: stp_r = $urandom_range(0, 32'h0010_0000);
            endcase
            set_route(lat_r[31:0], $urandom, $urandom, stp_r);
            no_gaps = ($urandom_range(0, 3) == 0);
            leg_len = $urandom_range(20, 60);
            send_tick(1'b1);
            sent++;
            for (int i = 0; i < leg_len; i++)
            begin
                send_tick($urandom_range(0, 7) == 0);
                sent++;
            end
        end

        settle();
        if (mismatches == 0 && positions_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
